/* rtl/core/ssidr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted set dense rank package
// Shared constants, beat types and control structures for the sorted set
// with dense rank and insert.
// ----------------------------------------------------------------------------
package ssidr_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned ScoreW     = 31;
  localparam int unsigned RankW      = 9;
  localparam int unsigned KindW      = 2;
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned GrpSize    = 16;
  localparam int unsigned GrpIdxW    = $clog2(GrpSize);
  localparam int unsigned NumGrp     = (TableDepth + GrpSize - 1) / GrpSize;
  localparam int unsigned PadDepth   = NumGrp * GrpSize;
  localparam int unsigned SumW       = (CntW + 1 > RankW) ? CntW + 1 : RankW;

  typedef enum logic [KindW-1:0] {
    KindLoad  = 2'd0,
    KindQuery = 2'd1,
    KindClear = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StCmp,
    StGrp,
    StFin
  } state_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ScoreW-1:0] score;
  } in_t;

  typedef struct packed {
    logic [RankW-1:0] rank;
    logic             dropped;
  } out_t;

  typedef struct packed {
    logic              cmp_en;
    logic              ins_en;
    logic [ScoreW-1:0] key;
  } cell_ctrl_t;

  typedef struct packed {
    logic               all_gt;
    logic [GrpIdxW-1:0] idx;
    logic               eq;
  } grp_t;

endpackage
`default_nettype wire

/* rtl/core/ssidr_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one stored score, compares it with the broadcast key and takes the
// key or its upper neighbour's score when an insertion shifts the row.
// ----------------------------------------------------------------------------
module ssidr_cell (
  input  logic                       clk_i,
  input  ssidr_pkg::cell_ctrl_t      ctrl_i,
  input  logic                       vld_i,
  input  logic                       prev_gt_i,
  input  logic [ssidr_pkg::ScoreW-1:0] prev_score_i,
  output logic [ssidr_pkg::ScoreW-1:0] score_o,
  output logic                       gt_o,
  output logic                       eq_o
);
  import ssidr_pkg::*;

  logic [ScoreW-1:0] score_q;
  logic              gt_q;
  logic              eq_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en) begin
      gt_q <= vld_i && (score_q > ctrl_i.key);
      eq_q <= vld_i && (score_q == ctrl_i.key);
    end
    if (ctrl_i.ins_en && !gt_q) begin
      score_q <= prev_gt_i ? ctrl_i.key : prev_score_i;
    end
  end

  assign score_o = score_q;
  assign gt_o    = gt_q;
  assign eq_o    = eq_q;

endmodule
`default_nettype wire

/* rtl/core/ssidr_group.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted set group encoder
// Finds the first cell of a group whose score is not greater than the key
// and registers its local index together with its equality flag.
// ----------------------------------------------------------------------------
module ssidr_group (
  input  logic                        clk_i,
  input  logic [ssidr_pkg::GrpSize-1:0] gt_i,
  input  logic [ssidr_pkg::GrpSize-1:0] eq_i,
  output ssidr_pkg::grp_t             grp_o
);
  import ssidr_pkg::*;

  grp_t grp_d;
  grp_t grp_q;

  always_comb begin
    grp_d.all_gt = &gt_i;
    grp_d.idx    = '0;
    grp_d.eq     = 1'b0;
    for (int i = GrpSize - 1; i >= 0; i--) begin
      if (!gt_i[i]) begin
        grp_d.idx = GrpIdxW'(i);
        grp_d.eq  = eq_i[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  assign grp_o = grp_q;

endmodule
`default_nettype wire

/* rtl/core/sorted_set_insert_dense_rank.sv */
// A load or query beat passes through the compare, group encode and commit
// steps over the cell row; the input stalls until the commit, and the commit
// waits while a result is due and the pending result beat is stalled. A query,
// or a load that is dropped, gives a result beat. A clear does not stall.
// Reset clears the entry count and the control state; cell scores keep
// whatever they hold and are never read until written.
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted set with dense rank and insert
// Keeps distinct scores in descending order in a row of cells, answers the
// dense rank of a query and inserts absent scores by shifting the row.
// ----------------------------------------------------------------------------
module sorted_set_insert_dense_rank (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ssidr_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ssidr_pkg::out_t out_data_o
);
  import ssidr_pkg::*;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ScoreW-1:0] key_q;
  logic              query_q;
  logic              out_vld_q, out_vld_d;
  out_t              out_q;

  cell_ctrl_t        ctrl;
  logic [TableDepth-1:0] cell_vld;
  logic [TableDepth-1:0] cell_gt;
  logic [TableDepth-1:0] cell_eq;
  logic [ScoreW-1:0] cell_score [TableDepth];
  logic [PadDepth-1:0] gt_pad;
  logic [PadDepth-1:0] eq_pad;
  grp_t              grp [NumGrp];

  logic              in_acc;
  logic [CntW-1:0]   pos;
  logic              present;
  logic              full;
  logic              dropped;
  logic              do_ins;
  logic              need_out;
  logic              commit;
  logic [SumW-1:0]   rank_sum;

  assign in_acc = in_valid_i && !in_stall_o;

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    assign cell_vld[i] = CntW'(i) < cnt_q;
    if (i == 0) begin : g_first
      ssidr_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .vld_i       (cell_vld[i]),
        .prev_gt_i   (1'b1),
        .prev_score_i('0),
        .score_o     (cell_score[i]),
        .gt_o        (cell_gt[i]),
        .eq_o        (cell_eq[i])
      );
    end else begin : g_rest
      ssidr_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .vld_i       (cell_vld[i]),
        .prev_gt_i   (cell_gt[i-1]),
        .prev_score_i(cell_score[i-1]),
        .score_o     (cell_score[i]),
        .gt_o        (cell_gt[i]),
        .eq_o        (cell_eq[i])
      );
    end
  end

  always_comb begin
    gt_pad = '0;
    eq_pad = '0;
    gt_pad[TableDepth-1:0] = cell_gt;
    eq_pad[TableDepth-1:0] = cell_eq;
  end

  for (genvar g = 0; g < NumGrp; g++) begin : g_grp
    ssidr_group u_group (
      .clk_i(clk_i),
      .gt_i (gt_pad[g*GrpSize +: GrpSize]),
      .eq_i (eq_pad[g*GrpSize +: GrpSize]),
      .grp_o(grp[g])
    );
  end

  always_comb begin
    pos     = CntW'(TableDepth);
    present = 1'b0;
    for (int g = NumGrp - 1; g >= 0; g--) begin
      if (!grp[g].all_gt) begin
        pos     = CntW'(g * GrpSize) + CntW'(grp[g].idx);
        present = grp[g].eq;
      end
    end
  end

  assign full     = cnt_q == CntW'(TableDepth);
  assign dropped  = !present && full;
  assign do_ins   = !present && !full;
  assign need_out = query_q || dropped;
  assign commit   = (state_q == StFin) && (!need_out || !out_vld_q || !out_stall_i);
  assign rank_sum = SumW'(pos) + SumW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc && (in_data_i.kind inside {KindLoad, KindQuery})) begin
          state_d = StCmp;
        end
      end
      StCmp:   state_d = StGrp;
      StGrp:   state_d = StFin;
      StFin: begin
        if (commit) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall_o  = state_q != StIdle;
    ctrl.cmp_en = state_q == StCmp;
    ctrl.ins_en = commit && do_ins;
    ctrl.key    = key_q;
    cnt_d       = cnt_q;
    if (in_acc && in_data_i.kind == KindClear) begin
      cnt_d = '0;
    end else if (commit && do_ins) begin
      cnt_d = cnt_q + CntW'(1);
    end
    if (commit && need_out) begin
      out_vld_d = 1'b1;
    end else if (out_stall_i) begin
      out_vld_d = out_vld_q;
    end else begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q   <= in_data_i.score;
      query_q <= in_data_i.kind == KindQuery;
    end
    if (commit && need_out) begin
      out_q.rank    <= rank_sum[RankW-1:0];
      out_q.dropped <= dropped;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TableDepth))
    else $error("Entry count exceeds the table depth.");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != $past(cnt_q) |-> cnt_q == '0 || cnt_q == $past(cnt_q) + CntW'(1))
    else $error("Entry count moved by more than one.");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == StFin))
    else $error("Result beat raised outside the commit step.");

  a_drop_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && dropped |=> cnt_q == CntW'(TableDepth) || cnt_q == '0)
    else $error("A dropped score changed the entry count.");
`endif

endmodule
`default_nettype wire
